FILE: hw/rtl/tafs_pkg.sv
package tafs_pkg;

    localparam int DIV_STEPS    = 17;
    localparam int SQRT_STEPS   = 17;
    localparam int CORDIC_STEPS = 20;

    localparam int PROD_W   = 32;
    localparam int NUM_W    = 33;
    localparam int Q_W      = 17;
    localparam int SQV_W    = 33;
    localparam int SQR_W    = 34;
    localparam int CORDIC_W = 34;
    localparam int ANG_W    = 26;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;

    localparam logic signed [ANG_W-1:0] DEG90_Q16  = ANG_W'(90 * 65536);
    localparam logic        [ANG_W-1:0] DEG180_Q16 = ANG_W'(180 * 65536);

    // sideband that travels with each request down the chain
    typedef struct packed {
        logic       valid;
        logic       neg;
        logic       force_zero;
        logic [1:0] status;
    } meta_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = ANG_W'(2949120);
            1:       v = ANG_W'(1740967);
            2:       v = ANG_W'(919879);
            3:       v = ANG_W'(466945);
            4:       v = ANG_W'(234379);
            5:       v = ANG_W'(117304);
            6:       v = ANG_W'(58666);
            7:       v = ANG_W'(29335);
            8:       v = ANG_W'(14668);
            9:       v = ANG_W'(7334);
            10:      v = ANG_W'(3667);
            11:      v = ANG_W'(1833);
            12:      v = ANG_W'(917);
            13:      v = ANG_W'(458);
            14:      v = ANG_W'(229);
            15:      v = ANG_W'(115);
            16:      v = ANG_W'(57);
            17:      v = ANG_W'(29);
            18:      v = ANG_W'(14);
            19:      v = ANG_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/triangle_angle_from_sides.sv
// Angle opposite side a of a triangle given its three sides (law of cosines).
// Input stream: s_tdata carries side_a, side_b, side_c (16 bits each, unsigned).
// Output stream: m_tdata carries angle_degrees (unsigned, ANGLE_FRAC_BITS fraction
// bits, 0..180 degrees) and a 2-bit status: ok, zero adjacent side, cosine clamped.
// Sides are masked to LENGTH_BITS bits before use.
// The chain runs through the input, squaring and cosine numerator/denominator
// registers, 17 cells of the cosine divider, the cosine square register,
// 17 cells of the square root, 20 CORDIC cells and the output register.
// It takes one request per cycle while not stalled; every cell is one pipeline stage.
// The whole chain advances on one enable: when the result register holds a
// request that the receiver does not take, the chain freezes and s_tready drops
// until m_tready returns. Nothing is lost or repeated across a stall.
// Reset clears the valid bits of every stage; no request is in flight afterward
// and the block takes a request in the first cycle after reset.
module triangle_angle_from_sides #(
    parameter int LENGTH_BITS     = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // side_a[15:0], side_b[31:16], side_c[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // angle_degrees[15:0], status[17:16], zero pad
);
    import tafs_pkg::*;

    localparam logic [15:0] LEN_MASK =
        (LENGTH_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << LENGTH_BITS) - 32'd1);
    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam logic [ANG_W-1:0] HALF = (SH == 0) ? '0 : ANG_W'(1) << ((SH == 0) ? 0 : SH - 1);
    localparam logic [15:0] ANGLE_MAX =
        ((180 << ANGLE_FRAC_BITS) > 65535) ? 16'hFFFF : 16'(180 << ANGLE_FRAC_BITS);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: masked sides
    meta_t       m1_reg;
    logic [15:0] a1_reg, b1_reg, c1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_reg.valid <= 1'b0;
        end else if (en) begin
            m1_reg.valid <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg.neg        <= 1'b0;
            m1_reg.force_zero <= 1'b0;
            m1_reg.status     <= ST_OK;
            a1_reg            <= s_tdata[15:0] & LEN_MASK;
            b1_reg            <= s_tdata[31:16] & LEN_MASK;
            c1_reg            <= s_tdata[47:32] & LEN_MASK;
        end
    end

    // stage 2: products
    meta_t             m2_reg;
    logic [PROD_W-1:0] aa2_reg, bb2_reg, cc2_reg, bc2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_reg.valid <= 1'b0;
        end else if (en) begin
            m2_reg.valid <= m1_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_reg.neg        <= 1'b0;
            m2_reg.force_zero <= 1'b0;
            m2_reg.status     <= (b1_reg == '0 || c1_reg == '0) ? ST_ZERO : ST_OK;
            aa2_reg           <= PROD_W'(a1_reg) * PROD_W'(a1_reg);
            bb2_reg           <= PROD_W'(b1_reg) * PROD_W'(b1_reg);
            cc2_reg           <= PROD_W'(c1_reg) * PROD_W'(c1_reg);
            bc2_reg           <= PROD_W'(b1_reg) * PROD_W'(c1_reg);
        end
    end

    // stage 3: |b^2 + c^2 - a^2| and 2bc
    logic [NUM_W-1:0] sum3;
    logic             neg3;
    logic [NUM_W-1:0] num3;
    logic [NUM_W-1:0] den3;
    meta_t            meta3;

    always_comb begin
        sum3  = NUM_W'(bb2_reg) + NUM_W'(cc2_reg);
        neg3  = sum3 < NUM_W'(aa2_reg);
        num3  = neg3 ? NUM_W'(aa2_reg) - sum3 : sum3 - NUM_W'(aa2_reg);
        den3  = {bc2_reg, 1'b0};
        meta3 = m2_reg;
        if (m2_reg.status == ST_ZERO) begin
            meta3.neg = 1'b0;
        end else begin
            meta3.neg = neg3;
            if (den3 < num3) begin
                meta3.status = ST_CLAMP;
            end else if (num3 >= den3) begin
                meta3.force_zero = 1'b1;     // cosine magnitude exactly one
            end
        end
    end

    meta_t            m3_reg;
    logic [NUM_W-1:0] n3_reg, d3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_reg.valid <= 1'b0;
        end else if (en) begin
            m3_reg.valid <= m2_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m3_reg.neg        <= meta3.neg;
            m3_reg.force_zero <= meta3.force_zero;
            m3_reg.status     <= meta3.status;
            n3_reg            <= num3;
            d3_reg            <= den3;
        end
    end

    // divider chain: 17 quotient bits of n/d
    meta_t            dv_meta [DIV_STEPS+1];
    logic [NUM_W-1:0] dv_rem  [DIV_STEPS+1];
    logic [NUM_W-1:0] dv_den  [DIV_STEPS+1];
    logic [Q_W-1:0]   dv_acc  [DIV_STEPS+1];

    assign dv_meta[0] = m3_reg;
    assign dv_rem[0]  = n3_reg;
    assign dv_den[0]  = d3_reg;
    assign dv_acc[0]  = '0;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        tafs_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .meta_in  (dv_meta[i]),
            .rem_in   (dv_rem[i]),
            .den_in   (dv_den[i]),
            .acc_in   (dv_acc[i]),
            .meta_out (dv_meta[i+1]),
            .rem_out  (dv_rem[i+1]),
            .den_out  (dv_den[i+1]),
            .acc_out  (dv_acc[i+1])
        );
    end

    // cosine rounding and radicand 2^32 - q^2
    logic [Q_W:0]   qr;
    logic [Q_W-1:0] q4;

    always_comb begin
        qr = {1'b0, dv_acc[DIV_STEPS]} + (Q_W+1)'(1);
        q4 = qr[Q_W:1];
    end

    meta_t            m4_reg;
    logic [Q_W-1:0]   q4_reg;
    logic [SQV_W-1:0] v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m4_reg.valid <= 1'b0;
        end else if (en) begin
            m4_reg.valid <= dv_meta[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_reg.neg        <= dv_meta[DIV_STEPS].neg;
            m4_reg.force_zero <= dv_meta[DIV_STEPS].force_zero || q4[Q_W-1];
            m4_reg.status     <= dv_meta[DIV_STEPS].status;
            q4_reg            <= q4;
            v4_reg            <= (SQV_W'(1) << 32) - SQV_W'(q4) * SQV_W'(q4);
        end
    end

    // square root chain
    meta_t            sq_meta [SQRT_STEPS+1];
    logic [SQV_W-1:0] sq_rad  [SQRT_STEPS+1];
    logic [SQR_W-1:0] sq_root [SQRT_STEPS+1];
    logic [Q_W-1:0]   sq_cos  [SQRT_STEPS+1];

    assign sq_meta[0] = m4_reg;
    assign sq_rad[0]  = v4_reg;
    assign sq_root[0] = '0;
    assign sq_cos[0]  = q4_reg;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        tafs_sqrt_cell #(.STEP(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .meta_in  (sq_meta[i]),
            .rad_in   (sq_rad[i]),
            .root_in  (sq_root[i]),
            .cos_in   (sq_cos[i]),
            .meta_out (sq_meta[i+1]),
            .rad_out  (sq_rad[i+1]),
            .root_out (sq_root[i+1]),
            .cos_out  (sq_cos[i+1])
        );
    end

    // CORDIC chain on (cos, sin) scaled by 2^14
    meta_t                     cr_meta [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] cr_x   [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] cr_y   [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]    cr_z   [CORDIC_STEPS+1];

    assign cr_meta[0] = sq_meta[SQRT_STEPS];
    assign cr_x[0]    = CORDIC_W'({sq_cos[SQRT_STEPS], 14'b0});
    assign cr_y[0]    = CORDIC_W'({sq_root[SQRT_STEPS][Q_W-1:0], 14'b0});
    assign cr_z[0]    = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        tafs_cordic_cell #(.STEP(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .meta_in  (cr_meta[i]),
            .x_in     (cr_x[i]),
            .y_in     (cr_y[i]),
            .z_in     (cr_z[i]),
            .meta_out (cr_meta[i+1]),
            .x_out    (cr_x[i+1]),
            .y_out    (cr_y[i+1]),
            .z_out    (cr_z[i+1])
        );
    end

    // final clamp, reflection, rounding
    meta_t                   mf;
    logic signed [ANG_W-1:0] zf;
    logic [ANG_W-1:0]        zc;
    logic [ANG_W-1:0]        zo;
    logic [ANG_W-1:0]        zr;
    logic [15:0]             angle_next;

    always_comb begin
        mf = cr_meta[CORDIC_STEPS];
        zf = cr_z[CORDIC_STEPS];
        if (mf.status != ST_OK || mf.force_zero || zf < 0) begin
            zc = '0;
        end else if (zf > DEG90_Q16) begin
            zc = DEG90_Q16;
        end else begin
            zc = zf;
        end
        zo = mf.neg ? DEG180_Q16 - zc : zc;
        zr = (zo + HALF) >> SH;
        angle_next = (zr > ANG_W'(16'hFFFF)) ? 16'hFFFF : zr[15:0];
    end

    logic        m_tvalid_reg;
    logic [15:0] angle_reg;
    logic [1:0]  status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= mf.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg  <= angle_next;
            status_reg <= mf.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, status_reg, angle_reg};

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (status_reg == ST_OK || status_reg == ST_ZERO ||
                      status_reg == ST_CLAMP))
        else $error("undefined status code");

    a_zero_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == ST_ZERO) |-> angle_reg == '0)
        else $error("zero side must give zero angle");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> angle_reg <= ANGLE_MAX)
        else $error("angle beyond 180 degrees");

    a_stall_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input blocked without output stall");

endmodule

FILE: hw/rtl/tafs_div_cell.sv
module tafs_div_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  tafs_pkg::meta_t               meta_in,
    input  logic [tafs_pkg::NUM_W-1:0]    rem_in,
    input  logic [tafs_pkg::NUM_W-1:0]    den_in,
    input  logic [tafs_pkg::Q_W-1:0]      acc_in,
    output tafs_pkg::meta_t               meta_out,
    output logic [tafs_pkg::NUM_W-1:0]    rem_out,
    output logic [tafs_pkg::NUM_W-1:0]    den_out,
    output logic [tafs_pkg::Q_W-1:0]      acc_out
);
    import tafs_pkg::*;

    logic [NUM_W:0]   shifted;
    logic             take;
    logic [NUM_W-1:0] rem_next;
    logic [Q_W-1:0]   acc_next;

    // one restoring quotient bit
    always_comb begin
        shifted  = {rem_in, 1'b0};
        take     = shifted >= {1'b0, den_in};
        rem_next = take ? NUM_W'(shifted - {1'b0, den_in}) : NUM_W'(shifted);
        acc_next = {acc_in[Q_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_out.valid <= 1'b0;
        end else if (en) begin
            meta_out.valid <= meta_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_out.neg        <= meta_in.neg;
            meta_out.force_zero <= meta_in.force_zero;
            meta_out.status     <= meta_in.status;
            rem_out             <= rem_next;
            den_out             <= den_in;
            acc_out             <= acc_next;
        end
    end

endmodule

FILE: hw/rtl/tafs_sqrt_cell.sv
module tafs_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  tafs_pkg::meta_t               meta_in,
    input  logic [tafs_pkg::SQV_W-1:0]    rad_in,
    input  logic [tafs_pkg::SQR_W-1:0]    root_in,
    input  logic [tafs_pkg::Q_W-1:0]      cos_in,
    output tafs_pkg::meta_t               meta_out,
    output logic [tafs_pkg::SQV_W-1:0]    rad_out,
    output logic [tafs_pkg::SQR_W-1:0]    root_out,
    output logic [tafs_pkg::Q_W-1:0]      cos_out
);
    import tafs_pkg::*;

    localparam logic [SQR_W-1:0] ONE = SQR_W'(1) << (32 - 2 * STEP);

    logic [SQR_W-1:0] trial;
    logic             take;
    logic [SQV_W-1:0] rad_next;
    logic [SQR_W-1:0] root_next;

    always_comb begin
        trial     = root_in + ONE;
        take      = {1'b0, rad_in} >= trial;
        rad_next  = take ? SQV_W'({1'b0, rad_in} - trial) : rad_in;
        root_next = take ? (root_in >> 1) + ONE : root_in >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_out.valid <= 1'b0;
        end else if (en) begin
            meta_out.valid <= meta_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_out.neg        <= meta_in.neg;
            meta_out.force_zero <= meta_in.force_zero;
            meta_out.status     <= meta_in.status;
            rad_out             <= rad_next;
            root_out            <= root_next;
            cos_out             <= cos_in;
        end
    end

endmodule

FILE: hw/rtl/tafs_cordic_cell.sv
module tafs_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  tafs_pkg::meta_t                       meta_in,
    input  logic signed [tafs_pkg::CORDIC_W-1:0]  x_in,
    input  logic signed [tafs_pkg::CORDIC_W-1:0]  y_in,
    input  logic signed [tafs_pkg::ANG_W-1:0]     z_in,
    output tafs_pkg::meta_t                       meta_out,
    output logic signed [tafs_pkg::CORDIC_W-1:0]  x_out,
    output logic signed [tafs_pkg::CORDIC_W-1:0]  y_out,
    output logic signed [tafs_pkg::ANG_W-1:0]     z_out
);
    import tafs_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = atan_q16(STEP);

    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [ANG_W-1:0]    z_next;

    // vectoring step: rotate toward y = 0
    always_comb begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (y_in > 0) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_out.valid <= 1'b0;
        end else if (en) begin
            meta_out.valid <= meta_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_out.neg        <= meta_in.neg;
            meta_out.force_zero <= meta_in.force_zero;
            meta_out.status     <= meta_in.status;
            x_out               <= x_next;
            y_out               <= y_next;
            z_out               <= z_next;
        end
    end

endmodule

FILE: bench/triangle_angle_checker.sv
module triangle_angle_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import tafs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] angle;
        logic [1:0]  status;
    } angle_result_t;

    angle_result_t expected_angles[$];

    localparam longint ATAN_DEG_Q16[20] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    // floor shift for signed values
    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 32;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [15:0] round_angle(longint z);
        longint unsigned v;
        v = (longint'(z) + 128) >> 8;
        return (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic angle_result_t predict_angle(logic [15:0] sa, logic [15:0] sb,
                                                    logic [15:0] sc);
        angle_result_t res;
        logic [33:0] sum, asq, num, den, rem;
        logic        obtuse;
        longint      cosq, sinq, x, y, z, dx, dy;
        longint unsigned acc;
        if (sb == 0 || sc == 0) begin
            res.angle = '0;
            res.status = ST_ZERO;
            return res;
        end
        sum = 34'(sb) * sb + 34'(sc) * sc;
        asq = 34'(sa) * sa;
        obtuse = sum < asq;
        num = obtuse ? asq - sum : sum - asq;
        den = (34'(sb) * sc) << 1;
        if (den < num) begin
            res.angle = round_angle(obtuse ? 180 * 65536 : 0);
            res.status = ST_CLAMP;
            return res;
        end
        if (num >= den) begin
            cosq = 65536;
        end else begin
            rem = num;
            acc = 0;
            for (int i = 0; i < 17; i++) begin
                rem = rem << 1;
                acc <<= 1;
                if (rem >= den) begin
                    rem -= den;
                    acc |= 1;
                end
            end
            cosq = longint'((acc + 1) >> 1);
        end
        if (cosq >= 65536) begin
            z = 0;
        end else begin
            sinq = int_sqrt(64'd4294967296 - cosq * cosq);
            x = cosq * 16384;
            y = sinq * 16384;
            z = 0;
            for (int i = 0; i < 20; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (y > 0) begin
                    x += dx; y -= dy; z += ATAN_DEG_Q16[i];
                end else begin
                    x -= dx; y += dy; z -= ATAN_DEG_Q16[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 90 * 65536) z = 90 * 65536;
        end
        if (obtuse) z = 180 * 65536 - z;
        res.angle = round_angle(z);
        res.status = ST_OK;
        return res;
    endfunction

    assign pending = expected_angles.size();

    always @(posedge aclk) begin
        angle_result_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_angles.push_back(predict_angle(s_tdata[15:0], s_tdata[31:16],
                                                        s_tdata[47:32]));
            if (m_tvalid && m_tready) begin
                if (expected_angles.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_angles.pop_front();
                    if (m_tdata[15:0] !== want.angle) begin
                        $error("angle_degrees: expected %0d, got %0d", want.angle,
                               m_tdata[15:0]);
                        fail_count <= fail_count + 1;
                    end else if (m_tdata[17:16] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               m_tdata[17:16]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/triangle_angle_from_sides_test.sv
module triangle_angle_from_sides_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles = 0;
    bit          timed_out = 0;

    always #4 aclk = ~aclk;

    triangle_angle_from_sides u_top (.*);

    triangle_angle_checker u_chk (.*);

    always @(posedge aclk) begin
        if (aresetn)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out) begin
            timed_out <= 1;
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_triangle(logic [15:0] sa, logic [15:0] sb, logic [15:0] sc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {sc, sb, sa};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_triangle();
        logic [15:0] sa, sb, sc;
        int kind;
        kind = int'($urandom_range(9));
        sb = 16'($urandom);
        sc = 16'($urandom);
        if (kind < 6) begin
            // well-formed: a between |b-c| and b+c
            sa = 16'($urandom_range((sb > sc ? sb - sc : sc - sb),
                                    (32'(sb) + sc > 65535) ? 65535 : sb + sc));
        end else if (kind < 8) begin
            sb = 16'($urandom_range(15, 1));
            sc = 16'($urandom_range(15, 1));
            sa = 16'($urandom_range(31));
        end else begin
            sa = 16'($urandom);
            if (kind == 9) sb = 0;
        end
        send_triangle(sa, sb, sc);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: zero sides, extremes, equilateral, right, degenerate, clamp
        send_triangle(0, 0, 0);
        send_triangle(5, 0, 7);
        send_triangle(5, 7, 0);
        send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_triangle(0, 16'hFFFF, 16'hFFFF);
        send_triangle(1, 1, 1);
        send_triangle(5, 3, 4);
        send_triangle(3, 4, 5);
        send_triangle(2, 1, 1);
        send_triangle(0, 1, 1);
        send_triangle(3, 1, 1);
        send_triangle(16'hFFFF, 1, 1);
        send_triangle(16'hFFFF, 16'h8000, 16'h7FFF);
        send_triangle(1, 16'hFFFF, 16'hFFFE);
        send_triangle(16'hAAAA, 16'h5555, 16'h5555);
        send_triangle(16'h5555, 16'hAAAA, 16'hAAAA);
        send_triangle(7, 7, 7);
        send_triangle(12, 7, 7);
        send_triangle(1, 65535, 1);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int i = 0; i < 220; i++) send_random_triangle();
        end
        s_tvalid <= 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/tafs_pkg.sv
hw/rtl/tafs_div_cell.sv
hw/rtl/tafs_sqrt_cell.sv
hw/rtl/tafs_cordic_cell.sv
hw/rtl/triangle_angle_from_sides.sv
bench/triangle_angle_checker.sv
bench/triangle_angle_from_sides_test.sv
